// File: src/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for pressure/temperature compensation
// Field widths, calibration register indexes, divider sizes and the
// sideband record that travels with an item through the divider.
// ----------------------------------------------------------------------------
package ptc_pkg;

  // Input and result field widths
  localparam int RAW_W   = 20;
  localparam int TEMP_W  = 32;
  localparam int PRESS_W = 32;

  // Calibration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int CAL_T_W    = 48;
  localparam int CAL_P_W    = 64;
  localparam int CAL_C_W    = 16;
  localparam int COEF_W     = 16;

  // Divider: 64-bit signed dividend, 31-bit signed divisor
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 31;
  localparam int DIV_STEPS = NUM_W;

  // Polynomial constants
  localparam logic signed [24:0] TF_OFFSET   = 25'sd128000;
  localparam logic [63:0]        NUM_SCALE   = 64'd3125;
  localparam logic [63:0]        V1_BIAS     = 64'h0000_8000_0000_0000;
  localparam logic [20:0]        RAW_FULL    = 21'd1048576;
  localparam logic signed [26:0] TEMP_ROUND  = 27'sd128;

  // Calibration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP    = 2'd0,
    CFG_PRESS_A = 2'd1,
    CFG_PRESS_B = 2'd2,
    CFG_PRESS_C = 2'd3
  } cfg_idx_t;

  // Sideband carried alongside the divide
  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic              zero;
  } side_t;

  // One finished result
  typedef struct packed {
    logic [TEMP_W-1:0]  temp;
    logic [PRESS_W-1:0] press;
    logic               pvalid;
  } result_t;

endpackage

// File: src/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div: pipelined signed divider
// Signed 64-bit by 31-bit division truncating toward zero, one quotient
// bit per stage: a sign stage, 64 restoring steps and a negate stage.
// ----------------------------------------------------------------------------
module ptc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        in_vld,
  input  logic [ptc_pkg::NUM_W-1:0]   in_num,
  input  logic [ptc_pkg::DEN_W-1:0]   in_den,
  input  ptc_pkg::side_t              in_side,
  output logic                        out_vld,
  output logic [ptc_pkg::NUM_W-1:0]   out_quo,
  output ptc_pkg::side_t              out_side
);

  localparam int NW = ptc_pkg::NUM_W;
  localparam int DW = ptc_pkg::DEN_W;
  localparam int NS = ptc_pkg::DIV_STEPS;

  logic                vld  [0:NS];
  logic [DW-1:0]       rem  [0:NS];
  logic [NW-1:0]       quo  [0:NS];
  logic [DW-1:0]       den  [0:NS];
  logic                neg  [0:NS];
  ptc_pkg::side_t      side [0:NS];

  // Sign stage: take magnitudes, remember the quotient sign
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (advance) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem[0]  <= '0;
      quo[0]  <= in_num[NW-1] ? (NW'(0) - in_num) : in_num;
      den[0]  <= in_den[DW-1] ? (DW'(0) - in_den) : in_den;
      neg[0]  <= in_num[NW-1] ^ in_den[DW-1];
      side[0] <= in_side;
    end
  end

  // Restoring steps: shift one dividend bit into the remainder per stage
  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem[k-1], quo[k-1][NW-1]};
    assign diff  = trial - {1'b0, den[k-1]};
    assign ge    = (trial >= {1'b0, den[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (advance) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo[k]  <= {quo[k-1][NW-2:0], ge};
        den[k]  <= den[k-1];
        neg[k]  <= neg[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  // Negate stage: restore the quotient sign
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_quo  <= neg[NS] ? (NW'(0) - quo[NS]) : quo[NS];
      out_side <= side[NS];
    end
  end

endmodule

// File: src/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation: barometric sensor compensation
// Applies the calibration polynomials to one raw temperature/pressure pair
// and returns temperature in 0.01 degC and pressure in Pa as Q24.8.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_wr_en              cfg_index, cfg_wr_data
//   in        in         in_valid / in_ready    raw_temp_reading, raw_press_reading
//   out       out        out_valid / out_ready  temperature_centi, pressure_q24_8,
//                                               pressure_valid
//
// One pair is taken per cycle while in_ready is high; each pair passes the
// front stages, the bit-per-stage divider and the back stages to the output.
// rst is synchronous and clears the valid bits and calibration registers.
// The whole pipeline halts only when both the output register and the
// spare register are full and the last stage holds an item.
// Calibration must only change while no item is in flight.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ptc_pkg::RAW_W-1:0]          raw_temp_reading,
  input  logic [ptc_pkg::RAW_W-1:0]          raw_press_reading,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ptc_pkg::TEMP_W-1:0]  temperature_centi,
  output logic [ptc_pkg::PRESS_W-1:0]        pressure_q24_8,
  output logic                               pressure_valid
);

  // Calibration registers
  logic [ptc_pkg::CAL_T_W-1:0] cal_t;
  logic [ptc_pkg::CAL_P_W-1:0] cal_pa;
  logic [ptc_pkg::CAL_P_W-1:0] cal_pb;
  logic [ptc_pkg::CAL_C_W-1:0] cal_pc;

  logic        [15:0] t1;
  logic signed [15:0] t2, t3;
  logic        [15:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  logic adv;

  // Stage registers
  logic s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld, s7_vld, s8_vld;
  logic p1_vld, p2_vld, p3_vld, p4_vld;

  logic signed [33:0] s1_aprod;
  logic        [31:0] s1_d2sq;
  logic        [19:0] s1_pr, s2_pr, s3_pr, s4_pr, s5_pr;
  logic signed [22:0] s2_a;
  logic signed [36:0] s2_bprod;
  logic signed [23:0] s3_tf;
  logic        [31:0] s4_temp, s5_temp, s6_temp, s7_temp;
  logic signed [49:0] s4_vsq;
  logic signed [40:0] s4_v1p5, s4_v1p2, s5_v1p5, s5_v1p2;
  logic        [63:0] s5_v2a, s5_v1a;
  logic        [63:0] s6_v2, s6_v1s, s6_base;
  logic        [63:0] s7_nb;
  logic        [30:0] s7_d, s8_d;
  logic        [63:0] s8_n;
  ptc_pkg::side_t     s8_side;

  logic               div_vld;
  logic        [63:0] div_quo;
  ptc_pkg::side_t     div_side;

  logic        [63:0] p1_quo, p1_hsq_lo, p1_p8p;
  logic        [31:0] p1_hsq_x;
  ptc_pkg::side_t     p1_side, p2_side, p3_side;
  logic        [63:0] p2_hh;
  logic        [39:0] p2_e2, p2_quo, p3_e1, p3_e2, p3_quo;
  ptc_pkg::result_t   p4_res;

  ptc_pkg::result_t   out_res, spare_res;
  logic               spare_vld;
  logic               push, pop;

  // Combinational stage values
  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic signed [33:0] d2sq_full;
  logic signed [22:0] b_term;
  logic signed [24:0] v1;
  logic signed [26:0] tscale;
  logic signed [65:0] v2a_full, v1a_full;
  logic        [20:0] pr_diff;
  logic        [79:0] v1m_full;
  logic        [63:0] hval;
  logic signed [79:0] p8p_full, e1_full;
  logic        [39:0] psum;

  // Write calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_t  <= '0;
      cal_pa <= '0;
      cal_pb <= '0;
      cal_pc <= '0;
    end else if (cfg_wr_en) begin
      unique case (ptc_pkg::cfg_idx_t'(cfg_index))
        ptc_pkg::CFG_TEMP:    cal_t  <= cfg_wr_data[ptc_pkg::CAL_T_W-1:0];
        ptc_pkg::CFG_PRESS_A: cal_pa <= cfg_wr_data;
        ptc_pkg::CFG_PRESS_B: cal_pb <= cfg_wr_data;
        ptc_pkg::CFG_PRESS_C: cal_pc <= cfg_wr_data[ptc_pkg::CAL_C_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack calibration words
  assign t1 = cal_t[15:0];
  assign t2 = $signed(cal_t[31:16]);
  assign t3 = $signed(cal_t[47:32]);
  assign p1 = cal_pa[15:0];
  assign p2 = $signed(cal_pa[31:16]);
  assign p3 = $signed(cal_pa[47:32]);
  assign p4 = $signed(cal_pa[63:48]);
  assign p5 = $signed(cal_pb[15:0]);
  assign p6 = $signed(cal_pb[31:16]);
  assign p7 = $signed(cal_pb[47:32]);
  assign p8 = $signed(cal_pb[63:48]);
  assign p9 = $signed(cal_pc);

  // Advance everything unless the spare register is full and the last stage holds an item
  assign adv      = !spare_vld || !p4_vld;
  assign in_ready = adv;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
      s8_vld <= 1'b0;
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
      s7_vld <= s6_vld;
      s8_vld <= s7_vld;
      p1_vld <= div_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
    end
  end

  // Temperature differences, fine temperature and pressure offsets
  always_comb begin
    d1        = $signed({1'b0, raw_temp_reading[19:3]}) - $signed({1'b0, t1, 1'b0});
    d2        = $signed({1'b0, raw_temp_reading[19:4]}) - $signed({1'b0, t1});
    d2sq_full = d2 * d2;
    b_term    = s2_bprod[36:14];
    v1        = $signed({s3_tf[23], s3_tf}) - ptc_pkg::TF_OFFSET;
    tscale    = ($signed({{3{s3_tf[23]}}, s3_tf}) <<< 2)
              + $signed({{3{s3_tf[23]}}, s3_tf}) + ptc_pkg::TEMP_ROUND;
    v2a_full  = s4_vsq * p6;
    v1a_full  = s4_vsq * p3;
    pr_diff   = ptc_pkg::RAW_FULL - {1'b0, s5_pr};
    v1m_full  = s6_v1s * p1;
  end

  // Front stages: temperature polynomial and pressure offset/sensitivity
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: linear and square terms
      s1_aprod <= d1 * t2;
      s1_d2sq  <= d2sq_full[31:0];
      s1_pr    <= raw_press_reading;
      // stage 2: scale linear term, multiply square by T3
      s2_a     <= s1_aprod[33:11];
      s2_bprod <= $signed({1'b0, s1_d2sq[31:12]}) * t3;
      s2_pr    <= s1_pr;
      // stage 3: fine temperature
      s3_tf    <= {s2_a[22], s2_a} + {b_term[22], b_term};
      s3_pr    <= s2_pr;
      // stage 4: temperature result, offset products
      s4_temp  <= {{13{tscale[26]}}, tscale[26:8]};
      s4_vsq   <= v1 * v1;
      s4_v1p5  <= v1 * p5;
      s4_v1p2  <= v1 * p2;
      s4_pr    <= s3_pr;
      // stage 5: square terms times P6 and P3
      s5_v2a   <= v2a_full[63:0];
      s5_v1a   <= v1a_full[63:0];
      s5_v1p5  <= s4_v1p5;
      s5_v1p2  <= s4_v1p2;
      s5_pr    <= s4_pr;
      s5_temp  <= s4_temp;
      // stage 6: sum offset and sensitivity terms
      s6_v2    <= s5_v2a + {{6{s5_v1p5[40]}}, s5_v1p5, 17'b0}
                + {{13{p4[15]}}, p4, 35'b0};
      s6_v1s   <= ptc_pkg::V1_BIAS + {{8{s5_v1a[63]}}, s5_v1a[63:8]}
                + {{11{s5_v1p2[40]}}, s5_v1p2, 12'b0};
      s6_base  <= {12'b0, pr_diff, 31'b0};
      s6_temp  <= s5_temp;
      // stage 7: divisor and raw numerator
      s7_d     <= v1m_full[63:33];
      s7_nb    <= s6_base - s6_v2;
      s7_temp  <= s6_temp;
      // stage 8: scale numerator, flag a zero divisor
      s8_n         <= s7_nb * ptc_pkg::NUM_SCALE;
      s8_d         <= s7_d;
      s8_side.temp <= s7_temp;
      s8_side.zero <= (s7_d == '0);
    end
  end

  ptc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .advance  (adv),
    .in_vld   (s8_vld),
    .in_num   (s8_n),
    .in_den   (s8_d),
    .in_side  (s8_side),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_side)
  );

  // Back-end combinational terms
  always_comb begin
    hval     = {{13{div_quo[63]}}, div_quo[63:13]};
    p8p_full = $signed(div_quo) * p8;
    e1_full  = $signed(p2_hh) * p9;
    psum     = p3_quo + p3_e1 + p3_e2;
  end

  // Back stages: quadratic and linear corrections, final scaling
  always_ff @(posedge clk) begin
    if (adv) begin
      // square of quotient split in 32-bit halves, P8 product
      p1_quo    <= div_quo;
      p1_hsq_lo <= hval[31:0] * hval[31:0];
      p1_hsq_x  <= hval[31:0] * hval[63:32];
      p1_p8p    <= p8p_full[63:0];
      p1_side   <= div_side;
      // assemble square, scale P8 term
      p2_hh     <= p1_hsq_lo + {p1_hsq_x[30:0], 1'b0, 32'b0};
      p2_e2     <= p1_p8p[58:19];
      p2_quo    <= p1_quo[39:0];
      p2_side   <= p1_side;
      // quadratic term times P9
      p3_e1     <= {e1_full[63], e1_full[63:25]};
      p3_e2     <= p2_e2;
      p3_quo    <= p2_quo;
      p3_side   <= p2_side;
      // sum, scale to Q24.8 and add P7 offset
      p4_res.temp   <= p3_side.temp;
      p4_res.press  <= p3_side.zero ? '0
                     : psum[39:8] + {{12{p7[15]}}, p7, 4'b0};
      p4_res.pvalid <= !p3_side.zero;
    end
  end

  // Output register with one spare entry
  assign push = p4_vld && adv;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      spare_vld <= 1'b0;
    end else if (pop) begin
      if (spare_vld) begin
        out_valid <= 1'b1;
        spare_vld <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        spare_vld <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (spare_vld) begin
        out_res <= spare_res;
      end else if (push) begin
        out_res <= p4_res;
      end
    end else if (push) begin
      if (out_valid) begin
        spare_res <= p4_res;
      end else begin
        out_res <= p4_res;
      end
    end
  end

  assign temperature_centi = $signed(out_res.temp);
  assign pressure_q24_8    = out_res.press;
  assign pressure_valid    = out_res.pvalid;

endmodule
